// File: design/obstacle_avoid_drive_controller_top_assert.svh
// Assertion macros for the obstacle avoid drive controller checker.
// Depends on nothing; taken in by the checker file with an include.
`ifndef OBSTACLE_AVOID_DRIVE_CONTROLLER_TOP_ASSERT_SVH
`define OBSTACLE_AVOID_DRIVE_CONTROLLER_TOP_ASSERT_SVH

// Clocked implication check, held off while reset is asserted
`define OADC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same check, but also evaluated during reset
`define OADC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/oadc_pkg.sv
// Shared types, codes and constants for the obstacle avoid drive controller.
// No dependencies; used by the top level, the divider and the checker.
package oadc_pkg;

    localparam int DIST_W   = 13;
    localparam int CM_W     = 9;
    localparam int HYST_W   = 6;
    localparam int MS_W     = 16;
    localparam int LIM_W    = 4;
    localparam int MISS_W   = 4;
    localparam int TIME_W   = 32;
    localparam int SPEED_W  = 8;
    localparam int PINS_W   = 4;
    localparam int CMD_W    = 3;
    localparam int NUM_SENS = 3;

    localparam logic [DIST_W-1:0] NO_ECHO  = 13'd6400;
    localparam logic [MISS_W-1:0] MISS_MAX = 4'd15;

    // Speed defaults for the top-level parameters
    localparam logic [SPEED_W-1:0] DEF_FULL_SPEED   = 8'd255;
    localparam logic [SPEED_W-1:0] DEF_CRUISE_SPEED = 8'd180;
    localparam logic [SPEED_W-1:0] DEF_CREEP_SPEED  = 8'd127;

    // Ramp divider: dividend is |cm diff| * |speed diff|, divisor a cm span
    localparam int DIVD_W  = CM_W + SPEED_W;
    localparam int DIVS_W  = CM_W;
    localparam int DIVC_W  = $clog2(DIVD_W + 1);
    localparam int RAMP_W  = DIVD_W + 2;

    // Stream payload widths (zero-filled to whole bytes)
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 16;

    // APB port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_FWD   = 3'd0,
        CMD_RIGHT = 3'd1,
        CMD_LEFT  = 3'd2,
        CMD_REV   = 3'd3,
        CMD_STOP  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_REV   = 2'd1,
        PH_PIVOT = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        REG_STOP_FRONT = 3'd0,
        REG_SLOW_FRONT = 3'd1,
        REG_MAX_FRONT  = 3'd2,
        REG_STOP_LAT   = 3'd3,
        REG_HYSTERESIS = 3'd4,
        REG_REVERSE_MS = 3'd5,
        REG_PIVOT_MS   = 3'd6,
        REG_GLITCH_LIM = 3'd7
    } reg_idx_t;

    // H-bridge patterns, IN1 in bit 3
    localparam logic [PINS_W-1:0] PINS_FWD   = 4'b1010;
    localparam logic [PINS_W-1:0] PINS_REV   = 4'b0101;
    localparam logic [PINS_W-1:0] PINS_LEFT  = 4'b0110;
    localparam logic [PINS_W-1:0] PINS_RIGHT = 4'b1001;
    localparam logic [PINS_W-1:0] PINS_STOP  = 4'b0000;

    // Request into the divider
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    // Result from the divider
    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [PINS_W-1:0] cmd_pins(input cmd_t cmd);
        logic [PINS_W-1:0] p;
        unique case (cmd)
            CMD_FWD:   p = PINS_FWD;
            CMD_RIGHT: p = PINS_RIGHT;
            CMD_LEFT:  p = PINS_LEFT;
            CMD_REV:   p = PINS_REV;
            default:   p = PINS_STOP;
        endcase
        return p;
    endfunction

endpackage

// File: design/oadc_div.sv
// Iterative restoring divider, one quotient bit per cycle, for the speed ramp.
// Depends on oadc_pkg for widths and the request/response structs.
module oadc_div
    import oadc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIVC_W-1:0] cnt_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] dvs_reg;

    logic [DIVS_W:0]   rem_sh;
    logic [DIVS_W:0]   rem_dif;
    logic              fits;

    // One trial subtract per cycle
    assign rem_sh  = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits    = rem_sh >= {1'b0, dvs_reg};
    assign rem_dif = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? rem_dif[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIVC_W'(DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: design/obstacle_avoid_drive_controller_top.sv
// Obstacle avoid drive controller: takes one sweep of three range readings and a
// millisecond time per transfer and gives one transfer of command, speed and
// H-bridge pins. Each item is handled alone: the block drops s_tready from
// acceptance until its result has been placed in the output register. After
// acceptance an item passes the decide and output states before m_tvalid, and
// the multiply and divide states between them when forward speed falls on the
// ramp between the stop and slow distances; there the restoring divider makes
// one quotient bit at a time. The finished result waits in the output register,
// so the next item can be accepted while it is still unclaimed. Registers are
// written over APB at byte address 4*index; pready is always high.
// Depends on oadc_pkg and oadc_div.
module obstacle_avoid_drive_controller_top
    import oadc_pkg::*;
#(
    parameter logic [SPEED_W-1:0] FULL_SPEED   = DEF_FULL_SPEED,
    parameter logic [SPEED_W-1:0] CRUISE_SPEED = DEF_CRUISE_SPEED,
    parameter logic [SPEED_W-1:0] CREEP_SPEED  = DEF_CREEP_SPEED
)
(
    input  logic                aclk,
    input  logic                aresetn,
    // Sensor sweep in
    input  logic                s_tvalid,
    output logic                s_tready,
    // [12:0] front_dist, [25:13] left_dist, [38:26] right_dist, [70:39] now_ms
    input  logic [S_DATA_W-1:0] s_tdata,
    // Drive command out
    output logic                m_tvalid,
    input  logic                m_tready,
    // [2:0] command, [10:3] speed, [14:11] bridge_pins
    output logic [M_DATA_W-1:0] m_tdata,
    // Configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // Configuration registers
    logic [CM_W-1:0]   stop_front_reg, slow_front_reg, max_front_reg, stop_lat_reg;
    logic [HYST_W-1:0] hyst_reg;
    logic [MS_W-1:0]   reverse_ms_reg, pivot_ms_reg;
    logic [LIM_W-1:0]  glitch_lim_reg;

    // Controller state
    state_t            state_reg, state_next;
    logic [DIST_W-1:0] held_reg [NUM_SENS];
    logic [DIST_W-1:0] held_next [NUM_SENS];
    logic [MISS_W-1:0] miss_reg [NUM_SENS];
    logic [MISS_W-1:0] miss_next [NUM_SENS];
    cmd_t              last_cmd_reg, last_cmd_next;
    phase_t            phase_reg, phase_next;
    logic [TIME_W-1:0] phase_start_reg, phase_start_next;
    logic              pivot_right_reg, pivot_right_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic              neg_reg, neg_next;
    logic              m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic              s_fire;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;
    logic [DIST_W-1:0] raw [NUM_SENS];
    logic [MISS_W-1:0] miss_inc [NUM_SENS];

    // Decision terms
    logic [DIST_W-1:0] f_d, l_d, r_d;
    logic [TIME_W-1:0] elapsed, piv_elapsed;
    logic              rev_run, rev_exp, piv_run;
    logic [CM_W:0]     ft, lt;
    logic              f_lo, l_lo, r_lo;
    cmd_t              dec_cmd;

    // Ramp terms
    logic [CM_W-1:0]    c_cm, num_mag, span;
    logic               num_neg, den_neg;
    logic [SPEED_W-1:0] den_mag;
    logic [DIVD_W-1:0]  product;
    logic signed [RAMP_W-1:0] q_s, v_s;
    logic [SPEED_W-1:0] ramp_speed;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign s_fire = s_tvalid && s_tready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_front_reg <= 9'd20;
            slow_front_reg <= 9'd60;
            max_front_reg  <= 9'd300;
            stop_lat_reg   <= 9'd15;
            hyst_reg       <= 6'd3;
            reverse_ms_reg <= 16'd400;
            pivot_ms_reg   <= 16'd500;
            glitch_lim_reg <= 4'd3;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_STOP_FRONT: stop_front_reg <= pwdata[CM_W-1:0];
                REG_SLOW_FRONT: slow_front_reg <= pwdata[CM_W-1:0];
                REG_MAX_FRONT:  max_front_reg  <= pwdata[CM_W-1:0];
                REG_STOP_LAT:   stop_lat_reg   <= pwdata[CM_W-1:0];
                REG_HYSTERESIS: hyst_reg       <= pwdata[HYST_W-1:0];
                REG_REVERSE_MS: reverse_ms_reg <= pwdata[MS_W-1:0];
                REG_PIVOT_MS:   pivot_ms_reg   <= pwdata[MS_W-1:0];
                REG_GLITCH_LIM: glitch_lim_reg <= pwdata[LIM_W-1:0];
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (cfg_idx)
            REG_STOP_FRONT: prdata = APB_DW'(stop_front_reg);
            REG_SLOW_FRONT: prdata = APB_DW'(slow_front_reg);
            REG_MAX_FRONT:  prdata = APB_DW'(max_front_reg);
            REG_STOP_LAT:   prdata = APB_DW'(stop_lat_reg);
            REG_HYSTERESIS: prdata = APB_DW'(hyst_reg);
            REG_REVERSE_MS: prdata = APB_DW'(reverse_ms_reg);
            REG_PIVOT_MS:   prdata = APB_DW'(pivot_ms_reg);
            REG_GLITCH_LIM: prdata = APB_DW'(glitch_lim_reg);
        endcase
    end

    // Glitch filter inputs, one lane per sensor
    assign raw[0] = s_tdata[DIST_W-1:0];
    assign raw[1] = s_tdata[2*DIST_W-1:DIST_W];
    assign raw[2] = s_tdata[3*DIST_W-1:2*DIST_W];

    always_comb begin
        for (int k = 0; k < NUM_SENS; k++) begin
            miss_inc[k] = (miss_reg[k] < MISS_MAX) ? miss_reg[k] + 1'b1 : miss_reg[k];
        end
    end

    // Recovery timing
    assign f_d = held_reg[0];
    assign l_d = held_reg[1];
    assign r_d = held_reg[2];
    assign elapsed     = now_reg - phase_start_reg;
    assign rev_run     = (phase_reg == PH_REV) && (elapsed < TIME_W'(reverse_ms_reg));
    assign rev_exp     = (phase_reg == PH_REV) && !rev_run;
    assign piv_elapsed = rev_exp ? '0 : elapsed;
    assign piv_run     = ((phase_reg == PH_PIVOT) || rev_exp)
                         && (piv_elapsed < TIME_W'(pivot_ms_reg));

    // Hysteretic thresholds, compared in sixteenths of a cm
    assign ft = {1'b0, stop_front_reg}
                + ((last_cmd_reg != CMD_FWD) ? (CM_W+1)'(hyst_reg) : '0);
    assign lt = {1'b0, stop_lat_reg}
                + ((last_cmd_reg != CMD_FWD) ? (CM_W+1)'(hyst_reg) : '0);
    assign f_lo = {1'b0, f_d} < {ft, 4'b0000};
    assign l_lo = {1'b0, l_d} < {lt, 4'b0000};
    assign r_lo = {1'b0, r_d} < {lt, 4'b0000};

    always_comb begin
        priority if (f_lo && l_lo && r_lo) dec_cmd = CMD_STOP;
        else if (f_lo)                     dec_cmd = CMD_REV;
        else if (l_lo)                     dec_cmd = CMD_RIGHT;
        else if (r_lo)                     dec_cmd = CMD_LEFT;
        else                               dec_cmd = CMD_FWD;
    end

    // Ramp numerator and divisor magnitudes
    assign c_cm    = f_d[DIST_W-1:4];
    assign num_neg = c_cm < stop_front_reg;
    assign num_mag = num_neg ? stop_front_reg - c_cm : c_cm - stop_front_reg;
    assign den_neg = CRUISE_SPEED < CREEP_SPEED;
    assign den_mag = den_neg ? CREEP_SPEED - CRUISE_SPEED : CRUISE_SPEED - CREEP_SPEED;
    assign product = DIVD_W'(num_mag) * DIVD_W'(den_mag);
    assign span    = slow_front_reg - stop_front_reg;

    // Signed ramp value and its clamp
    assign q_s = neg_reg ? -$signed({2'b00, div_rsp.quotient})
                         :  $signed({2'b00, div_rsp.quotient});
    assign v_s = $signed({{(RAMP_W-SPEED_W){1'b0}}, CREEP_SPEED}) + q_s;

    always_comb begin
        priority if (v_s < $signed({{(RAMP_W-SPEED_W){1'b0}}, CREEP_SPEED}))
            ramp_speed = CREEP_SPEED;
        else if (v_s > $signed({{(RAMP_W-SPEED_W){1'b0}}, CRUISE_SPEED}))
            ramp_speed = CRUISE_SPEED;
        else
            ramp_speed = v_s[SPEED_W-1:0];
    end

    assign div_req.dividend = product;
    assign div_req.divisor  = span;
    assign div_req.start    = (state_reg == ST_MUL);

    oadc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer: next state and next values
    always_comb begin
        state_next       = state_reg;
        held_next        = held_reg;
        miss_next        = miss_reg;
        last_cmd_next    = last_cmd_reg;
        phase_next       = phase_reg;
        phase_start_next = phase_start_reg;
        pivot_right_next = pivot_right_reg;
        now_next         = now_reg;
        speed_next       = speed_reg;
        neg_next         = neg_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    now_next = s_tdata[3*DIST_W+TIME_W-1:3*DIST_W];
                    for (int k = 0; k < NUM_SENS; k++) begin
                        if (raw[k] >= NO_ECHO) begin
                            miss_next[k] = miss_inc[k];
                            if (miss_inc[k] >= glitch_lim_reg) begin
                                held_next[k] = NO_ECHO;
                            end
                        end else begin
                            miss_next[k] = '0;
                            held_next[k] = raw[k];
                        end
                    end
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_OUT;
                speed_next = CREEP_SPEED;
                priority if (rev_run) begin
                    last_cmd_next = CMD_REV;
                end else if (piv_run) begin
                    last_cmd_next = pivot_right_reg ? CMD_RIGHT : CMD_LEFT;
                    phase_next    = PH_PIVOT;
                    if (rev_exp) begin
                        phase_start_next = now_reg;
                    end
                end else begin
                    last_cmd_next = dec_cmd;
                    phase_next    = PH_NONE;
                    if (dec_cmd == CMD_REV) begin
                        phase_next       = PH_REV;
                        phase_start_next = now_reg;
                        pivot_right_next = r_d > l_d;
                    end else if (dec_cmd == CMD_STOP) begin
                        speed_next = '0;
                    end else if (dec_cmd == CMD_FWD) begin
                        // Forward speed rule; the ramp goes through the divider
                        priority if (f_d >= {max_front_reg, 4'b0000}) begin
                            speed_next = FULL_SPEED;
                        end else if (f_d > {slow_front_reg, 4'b0000}) begin
                            speed_next = CRUISE_SPEED;
                        end else if (slow_front_reg <= stop_front_reg) begin
                            speed_next = CREEP_SPEED;
                        end else begin
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL: begin
                neg_next   = num_neg ^ den_neg;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    speed_next = ramp_speed;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, cmd_pins(last_cmd_reg), speed_reg,
                                    last_cmd_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            last_cmd_reg    <= CMD_FWD;
            phase_reg       <= PH_NONE;
            phase_start_reg <= '0;
            pivot_right_reg <= 1'b0;
            for (int k = 0; k < NUM_SENS; k++) begin
                held_reg[k] <= NO_ECHO;
                miss_reg[k] <= '0;
            end
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            last_cmd_reg    <= last_cmd_next;
            phase_reg       <= phase_next;
            phase_start_reg <= phase_start_next;
            pivot_right_reg <= pivot_right_next;
            held_reg        <= held_next;
            miss_reg        <= miss_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        now_reg    <= now_next;
        speed_reg  <= speed_next;
        neg_reg    <= neg_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: design/oadc_checker.sv
// Port-level checks for the obstacle avoid drive controller, bound to the top.
// Depends on oadc_pkg and the assertion macro header.
`include "obstacle_avoid_drive_controller_top_assert.svh"

module oadc_checker
    import oadc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result transfer keeps its payload
    `OADC_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result changed while stalled")

    // One item at a time: no acceptance straight after another
    `OADC_ASSERT(a_one_item, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "input accepted while busy")

    // Command stays within the defined codes
    `OADC_ASSERT(a_cmd_code, aclk, aresetn, m_tvalid |-> (m_tdata[2:0] <= CMD_STOP), "undefined command")

    // Emergency stop drives nothing
    `OADC_ASSERT(a_stop_idle, aclk, aresetn, (m_tvalid && (m_tdata[2:0] == CMD_STOP)) |-> (m_tdata[14:3] == '0), "stop with drive")

    // Forward always uses the forward bridge pattern and a nonzero speed
    `OADC_ASSERT(a_fwd_pins, aclk, aresetn, (m_tvalid && (m_tdata[2:0] == CMD_FWD)) |-> ((m_tdata[14:11] == PINS_FWD) && (m_tdata[10:3] != '0)), "bad forward drive")

endmodule

bind obstacle_avoid_drive_controller_top oadc_checker u_oadc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
